// ===== rtl/core/h264rtp_pkg.sv =====
// Shared types and constants for the H.264 RTP packetizer.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none
package h264rtp_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [1:0] CFG_MAX_PAYLOAD  = 2'd0;
  localparam logic [1:0] CFG_SCALE_ENABLE = 2'd1;
  localparam logic [1:0] CFG_SCALE        = 2'd2;
  localparam logic [1:0] CFG_SOURCE_ID    = 2'd3;

  localparam logic [13:0] MAX_PAYLOAD_RST = 14'd1400;
  localparam logic [13:0] MIN_PAYLOAD     = 14'd3;
  localparam logic [13:0] FU_OVERHEAD     = 14'd2;
  localparam logic [7:0]  SCALE_RST       = 8'd1;

  localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
  localparam logic [4:0] NAL_TYPE_PPS = 5'd8;
  localparam logic [4:0] NAL_TYPE_FUA = 5'd28;

  typedef struct packed {
    logic [13:0] max_pl;   // max payload, clamped to the minimum
    logic [13:0] dmax;     // data bytes per FU-A fragment
    logic        scale_en;
    logic [7:0]  scale;
    logic [31:0] ssrc;
  } cfg_t;

  // one queued job: a single result, or FU indicator + FU header + data byte
  typedef struct packed {
    logic        triple;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [23:0] plen;
    logic [15:0] seq;
    logic [31:0] pts;
    logic        marker;
    logic        frame_begin;
  } job_t;

  typedef enum logic [1:0] {
    BK_HEAD  = 2'd0,
    BK_FUHDR = 2'd1,
    BK_DATA  = 2'd2
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/h264_rtp_packetizer_top.sv =====
// H.264 RTP packetizer (single NAL unit packets and FU-A fragments).
// The results of a byte pass the input stage register, the job queue and the output register.
// Throughput: one byte per cycle while the queue has room; a byte that opens an FU-A
// fragment yields three results and holds the output register for all three, so a
// steady run of such bytes (smallest payload limit) stalls the input while they drain.
// Reset: rst_n synchronous, active low; clears all control state, config to defaults.
`default_nettype none
module h264_rtp_packetizer_top
  import h264rtp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_nal_byte,
  input  wire logic        in_nal_first,
  input  wire logic [23:0] in_nal_length,
  input  wire logic [31:0] in_decode_stamp,
  input  wire logic        in_frame_begin,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_packet_first,
  output logic             out_packet_last,
  output logic [23:0]      out_packet_length,
  output logic [15:0]      out_sequence_number,
  output logic [31:0]      out_timestamp,
  output logic             out_marker,
  output logic             out_frame_start_out,
  output logic [31:0]      out_source_id,
  output logic             out_run_last
);

  cfg_t cfg;
  job_t push_job;
  job_t head_job;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  h264rtp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  h264rtp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_nal_byte     (in_nal_byte),
    .in_nal_first    (in_nal_first),
    .in_nal_length   (in_nal_length),
    .in_decode_stamp (in_decode_stamp),
    .in_frame_begin  (in_frame_begin),
    .q_push          (q_push),
    .q_job           (push_job),
    .q_full          (q_full)
  );

  h264rtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_job),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (head_job),
    .empty (q_empty)
  );

  h264rtp_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .job                 (head_job),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte            (out_byte),
    .out_packet_first    (out_packet_first),
    .out_packet_last     (out_packet_last),
    .out_packet_length   (out_packet_length),
    .out_sequence_number (out_sequence_number),
    .out_timestamp       (out_timestamp),
    .out_marker          (out_marker),
    .out_frame_start_out (out_frame_start_out),
    .out_source_id       (out_source_id),
    .out_run_last        (out_run_last)
  );

endmodule
`default_nettype wire

// ===== rtl/core/h264rtp_cfg.sv =====
// Configuration register file for the H.264 RTP packetizer.
// Depends on h264rtp_pkg; derives the clamped size and fragment data size on write.
`default_nettype none
module h264rtp_cfg
  import h264rtp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output cfg_t             cfg
);

  cfg_t        cfg_r;
  cfg_t        cfg_nxt;
  logic [13:0] wr_max;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;
  assign wr_max   = (cfg_data[13:0] < MIN_PAYLOAD) ? MIN_PAYLOAD : cfg_data[13:0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_PAYLOAD: begin
          cfg_nxt.max_pl = wr_max;
          cfg_nxt.dmax   = wr_max - FU_OVERHEAD;
        end
        CFG_SCALE_ENABLE: cfg_nxt.scale_en = cfg_data[0];
        CFG_SCALE:        cfg_nxt.scale    = cfg_data[7:0];
        CFG_SOURCE_ID:    cfg_nxt.ssrc     = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_pl   <= MAX_PAYLOAD_RST;
      cfg_r.dmax     <= MAX_PAYLOAD_RST - FU_OVERHEAD;
      cfg_r.scale_en <= 1'b0;
      cfg_r.scale    <= SCALE_RST;
      cfg_r.ssrc     <= 32'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/h264rtp_front.sv =====
// Front end: accepts NAL bytes, forms pts, tracks NAL/fragment state and
// pushes result jobs into the queue. Depends on h264rtp_pkg.
`default_nettype none
module h264rtp_front
  import h264rtp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_nal_byte,
  input  wire logic        in_nal_first,
  input  wire logic [23:0] in_nal_length,
  input  wire logic [31:0] in_decode_stamp,
  input  wire logic        in_frame_begin,
  output logic             q_push,
  output job_t             q_job,
  input  wire logic        q_full
);

  // input stage
  logic        a_valid_r, a_valid_nxt;
  logic [7:0]  a_byte_r;
  logic        a_first_r;
  logic [23:0] a_len_r;
  logic [31:0] a_pts_r;
  logic [31:0] a_dts_r;
  logic [31:0] a_dts_p1_r;
  logic        a_fb_r;
  logic        in_acc;
  logic [39:0] prod;

  // NAL state
  logic        nudge_r, nudge_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic        frag_r, frag_nxt;
  logic [7:0]  fu_ind_r, fu_ind_nxt;
  logic [4:0]  fu_type_r, fu_type_nxt;
  logic        fu_started_r, fu_started_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [13:0] fill_r, fill_nxt;
  logic [31:0] cur_pts_r, cur_pts_nxt;
  logic        cur_mk_r, cur_mk_nxt;
  logic        cur_fb_r, cur_fb_nxt;

  logic        push_req;
  logic        b_adv;
  logic        hit;
  logic        mk_first;
  logic        big;
  logic [24:0] r0;
  logic        fin;
  logic [13:0] d;
  logic        last;
  logic [15:0] seq_prev;

  assign prod     = {8'd0, in_decode_stamp} * {32'd0, cfg.scale};
  assign b_adv    = a_valid_r && (!push_req || !q_full);
  assign in_stall = a_valid_r && !b_adv;
  assign in_acc   = in_valid && !in_stall;
  assign q_push   = a_valid_r && push_req && !q_full;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_acc) begin
      a_valid_nxt = 1'b1;
    end else if (b_adv) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_byte_r   <= in_nal_byte;
      a_first_r  <= in_nal_first;
      a_len_r    <= (in_nal_length == 24'd0) ? 24'd1 : in_nal_length;
      a_pts_r    <= cfg.scale_en ? prod[31:0] : in_decode_stamp;
      a_dts_r    <= in_decode_stamp;
      a_dts_p1_r <= in_decode_stamp + 32'd1;
      a_fb_r     <= in_frame_begin;
    end
  end

  // compare against the nudged previous pts in parallel with the plain one
  assign hit      = nudge_r && (prev_r == a_dts_r);
  assign mk_first = ((a_byte_r[4:0] == NAL_TYPE_SPS) || (a_byte_r[4:0] == NAL_TYPE_PPS)) ? 1'b0 :
                    (hit ? (a_pts_r != a_dts_p1_r) : (a_pts_r != prev_r));
  assign big      = a_len_r > {10'd0, cfg.max_pl};
  assign r0       = {1'b0, rem_r} + {11'd0, fill_r};
  assign fin      = r0 <= {11'd0, cfg.dmax};
  assign d        = fin ? r0[13:0] : cfg.dmax;
  assign last     = ({1'b0, fill_r} + 15'd1) >= {1'b0, d};
  assign seq_prev = seq_r - 16'd1;

  always_comb begin
    nudge_nxt      = nudge_r;
    prev_nxt       = prev_r;
    seq_nxt        = seq_r;
    frag_nxt       = frag_r;
    fu_ind_nxt     = fu_ind_r;
    fu_type_nxt    = fu_type_r;
    fu_started_nxt = fu_started_r;
    rem_nxt        = rem_r;
    fill_nxt       = fill_r;
    cur_pts_nxt    = cur_pts_r;
    cur_mk_nxt     = cur_mk_r;
    cur_fb_nxt     = cur_fb_r;
    push_req       = 1'b0;

    q_job             = '0;
    q_job.data        = a_byte_r;
    q_job.fu_ind      = fu_ind_r;
    q_job.fu_hdr      = {~fu_started_r, fin, 1'b0, fu_type_r};
    q_job.pts         = cur_pts_r;
    q_job.frame_begin = cur_fb_r;
    q_job.marker      = cur_mk_r;
    q_job.seq         = seq_prev;

    if (a_first_r) begin
      nudge_nxt   = nudge_r & ~hit;
      prev_nxt    = a_pts_r;
      cur_pts_nxt = a_pts_r;
      cur_mk_nxt  = mk_first;
      cur_fb_nxt  = a_fb_r;
      rem_nxt     = a_len_r - 24'd1;
      if (big) begin
        frag_nxt       = 1'b1;
        fill_nxt       = 14'd0;
        fu_ind_nxt     = {a_byte_r[7:5], NAL_TYPE_FUA};
        fu_type_nxt    = a_byte_r[4:0];
        fu_started_nxt = 1'b0;
      end else begin
        frag_nxt          = 1'b0;
        fill_nxt          = 14'd1;
        push_req          = 1'b1;
        q_job.first       = 1'b1;
        q_job.last        = (a_len_r == 24'd1);
        q_job.plen        = a_len_r;
        q_job.seq         = seq_r;
        q_job.pts         = a_pts_r;
        q_job.marker      = mk_first;
        q_job.frame_begin = a_fb_r;
        seq_nxt           = seq_r + 16'd1;
      end
    end else if (rem_r != 24'd0) begin
      push_req = 1'b1;
      rem_nxt  = rem_r - 24'd1;
      if (!frag_r) begin
        q_job.last = (rem_r == 24'd1);
        q_job.plen = {10'd0, fill_r} + rem_r;
        fill_nxt   = fill_r + 14'd1;
      end else begin
        q_job.last   = last;
        q_job.plen   = {10'd0, d + FU_OVERHEAD};
        q_job.marker = fin;
        fill_nxt     = last ? 14'd0 : (fill_r + 14'd1);
        // open a new fragment: indicator and header go out ahead of the byte
        if (fill_r == 14'd0) begin
          q_job.triple   = 1'b1;
          q_job.seq      = seq_r;
          seq_nxt        = seq_r + 16'd1;
          fu_started_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nudge_r      <= 1'b1;
      prev_r       <= 32'd0;
      seq_r        <= 16'd0;
      frag_r       <= 1'b0;
      fu_ind_r     <= 8'd0;
      fu_type_r    <= 5'd0;
      fu_started_r <= 1'b0;
      rem_r        <= 24'd0;
      fill_r       <= 14'd0;
      cur_pts_r    <= 32'd0;
      cur_mk_r     <= 1'b0;
      cur_fb_r     <= 1'b0;
    end else if (b_adv) begin
      nudge_r      <= nudge_nxt;
      prev_r       <= prev_nxt;
      seq_r        <= seq_nxt;
      frag_r       <= frag_nxt;
      fu_ind_r     <= fu_ind_nxt;
      fu_type_r    <= fu_type_nxt;
      fu_started_r <= fu_started_nxt;
      rem_r        <= rem_nxt;
      fill_r       <= fill_nxt;
      cur_pts_r    <= cur_pts_nxt;
      cur_mk_r     <= cur_mk_nxt;
      cur_fb_r     <= cur_fb_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/h264rtp_queue.sv =====
// Job queue between the front end and the back end of the packetizer.
// Depends on h264rtp_pkg for the job type.
`default_nettype none
module h264rtp_queue
  import h264rtp_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t din,
  output logic      full,
  input  wire logic pop,
  output job_t      dout,
  output logic      empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/h264rtp_back.sv =====
// Back end: expands queued jobs into result items and holds them in the
// output register. Depends on h264rtp_pkg.
`default_nettype none
module h264rtp_back
  import h264rtp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire job_t  job,
  input  wire logic  q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic [7:0]  out_byte,
  output logic        out_packet_first,
  output logic        out_packet_last,
  output logic [23:0] out_packet_length,
  output logic [15:0] out_sequence_number,
  output logic [31:0] out_timestamp,
  output logic        out_marker,
  output logic        out_frame_start_out,
  output logic [31:0] out_source_id,
  output logic        out_run_last
);

  back_state_t state_r, state_nxt;
  logic        ov_r, ov_nxt;
  logic        load;
  logic        emit;
  logic [7:0]  res_byte;
  logic        res_pf;
  logic        res_pl;
  logic        res_rl;

  logic [7:0]  byte_r;
  logic        pf_r;
  logic        pl_r;
  logic [23:0] plen_r;
  logic [15:0] seq_r;
  logic [31:0] pts_r;
  logic        mk_r;
  logic        fb_r;
  logic [31:0] ssrc_r;
  logic        rl_r;

  assign load = !ov_r || !out_stall;
  assign emit = load && !q_empty;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r;
    q_pop     = 1'b0;
    res_byte  = job.data;
    res_pf    = job.first;
    res_pl    = job.last;
    res_rl    = 1'b1;
    if (load) begin
      ov_nxt = !q_empty;
    end
    unique case (state_r)
      BK_HEAD: begin
        if (job.triple) begin
          res_byte = job.fu_ind;
          res_pf   = 1'b1;
          res_pl   = 1'b0;
          res_rl   = 1'b0;
          if (emit) begin
            state_nxt = BK_FUHDR;
          end
        end else begin
          q_pop = emit;
        end
      end
      BK_FUHDR: begin
        res_byte = job.fu_hdr;
        res_pf   = 1'b0;
        res_pl   = 1'b0;
        res_rl   = 1'b0;
        if (emit) begin
          state_nxt = BK_DATA;
        end
      end
      BK_DATA: begin
        res_pf = 1'b0;
        q_pop  = emit;
        if (emit) begin
          state_nxt = BK_HEAD;
        end
      end
      default: state_nxt = BK_HEAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_HEAD;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= res_byte;
      pf_r   <= res_pf;
      pl_r   <= res_pl;
      plen_r <= job.plen;
      seq_r  <= job.seq;
      pts_r  <= job.pts;
      mk_r   <= job.marker;
      fb_r   <= job.frame_begin;
      ssrc_r <= cfg.ssrc;
      rl_r   <= res_rl;
    end
  end

  assign out_valid           = ov_r;
  assign out_byte            = byte_r;
  assign out_packet_first    = pf_r;
  assign out_packet_last     = pl_r;
  assign out_packet_length   = plen_r;
  assign out_sequence_number = seq_r;
  assign out_timestamp       = pts_r;
  assign out_marker          = mk_r;
  assign out_frame_start_out = fb_r;
  assign out_source_id       = ssrc_r;
  assign out_run_last        = rl_r;

endmodule
`default_nettype wire
